// ----- sv/txtesc_pkg.sv -----
// ----------------------------------------------------------------------------
// txtesc_pkg
// Shared types, register map and escape tables of the text escape encoder.
// ----------------------------------------------------------------------------
package txtesc_pkg;

  // escape_mode register encoding
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_JSON  = 2'd1,
    MODE_URL   = 2'd2,
    MODE_XML   = 2'd3
  } mode_t;

  // register map
  localparam int          PADDR_W          = 3;
  localparam logic [2:0]  ADDR_ESCAPE_MODE = 3'd0;

  // kind of run that one text byte turns into
  typedef enum logic [1:0] {
    SEQ_PASS = 2'd0,
    SEQ_JSON = 2'd1,
    SEQ_URL  = 2'd2,
    SEQ_XML  = 2'd3
  } seq_t;

  // classified byte, as it travels from front to back
  typedef struct packed {
    seq_t       seq;
    logic [7:0] data;
  } desc_t;

  // descriptor queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // run position, enough for the longest run of six bytes
  localparam int IDX_W = 3;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PCT   = 8'h25;

  // entities, left aligned in six bytes
  localparam logic [47:0] ENT_QUOT = "&quot;";
  localparam logic [47:0] ENT_APOS = "&apos;";
  localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};
  localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};

  // bytes that url escaping leaves alone
  function automatic logic url_keeps(input logic [7:0] b);
    logic keep;
    keep = 1'b0;
    if (b >= "a" && b <= "z") keep = 1'b1;
    if (b >= "A" && b <= "Z") keep = 1'b1;
    if (b >= "0" && b <= "9") keep = 1'b1;
    if (b == "-" || b == "_" || b == "." || b == "~") keep = 1'b1;
    return keep;
  endfunction

  // pick the run kind for one byte under the current mode
  function automatic seq_t classify(input mode_t mode, input logic [7:0] b);
    seq_t s;
    s = SEQ_PASS;
    case (mode)
      MODE_JSON: begin
        if (b inside {CH_QUOTE, CH_BSL, CH_TAB, CH_CR, CH_LF}) s = SEQ_JSON;
      end
      MODE_URL: begin
        if (!url_keeps(b)) s = SEQ_URL;
      end
      MODE_XML: begin
        if (b inside {CH_QUOTE, CH_APOS, CH_AMP, CH_LT, CH_GT}) s = SEQ_XML;
      end
      default: s = SEQ_PASS;
    endcase
    return s;
  endfunction

  // entity text for an xml escaped byte
  function automatic logic [47:0] xml_entity(input logic [7:0] b);
    logic [47:0] e;
    case (b)
      CH_QUOTE: e = ENT_QUOT;
      CH_APOS:  e = ENT_APOS;
      CH_AMP:   e = ENT_AMP;
      CH_LT:    e = ENT_LT;
      default:  e = ENT_GT;
    endcase
    return e;
  endfunction

  // number of bytes in a run
  function automatic logic [IDX_W-1:0] seq_len(input desc_t d);
    logic [IDX_W-1:0] n;
    case (d.seq)
      SEQ_JSON: n = 3'd2;
      SEQ_URL:  n = 3'd3;
      SEQ_XML: begin
        case (d.data)
          CH_QUOTE, CH_APOS: n = 3'd6;
          CH_AMP:            n = 3'd5;
          default:           n = 3'd4;
        endcase
      end
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = {4'h0, d} + 8'h30;
    else           c = {4'h0, d} + 8'h37;
    return c;
  endfunction

  // one byte out of a six byte string
  function automatic logic [7:0] pick6(input logic [47:0] s, input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = s[47:40];
      3'd1:    c = s[39:32];
      3'd2:    c = s[31:24];
      3'd3:    c = s[23:16];
      3'd4:    c = s[15:8];
      default: c = s[7:0];
    endcase
    return c;
  endfunction

  // byte at a given position of a run
  function automatic logic [7:0] seq_char(input desc_t d, input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (d.seq)
      SEQ_JSON: begin
        if (i == 3'd0) begin
          c = CH_BSL;
        end else begin
          case (d.data)
            CH_TAB:  c = "t";
            CH_CR:   c = "r";
            CH_LF:   c = "n";
            default: c = d.data;
          endcase
        end
      end
      SEQ_URL: begin
        case (i)
          3'd0:    c = CH_PCT;
          3'd1:    c = hex_char(d.data[7:4]);
          default: c = hex_char(d.data[3:0]);
        endcase
      end
      SEQ_XML:  c = pick6(xml_entity(d.data), i);
      default:  c = d.data;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/txtesc_front.sv -----
// ----------------------------------------------------------------------------
// txtesc_front
// Accepts text bytes and classifies each into the kind of run it expands to.
// ----------------------------------------------------------------------------
module txtesc_front (
  input  txtesc_pkg::mode_t mode,
  input  logic [7:0]        in_byte,
  input  logic              push,
  input  logic              q_full,
  output logic              q_wr,
  output txtesc_pkg::desc_t q_wr_desc
);
  import txtesc_pkg::*;

  // transfer a pushed byte into the queue whenever there is room
  assign q_wr = push && !q_full;

  // classify under the current mode
  always_comb begin
    q_wr_desc.seq  = classify(mode, in_byte);
    q_wr_desc.data = in_byte;
  end

endmodule

// ----- sv/txtesc_queue.sv -----
// ----------------------------------------------------------------------------
// txtesc_queue
// Short descriptor queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module txtesc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  txtesc_pkg::desc_t wr_desc,
  output logic              full,
  input  logic              rd,
  output logic              valid,
  output txtesc_pkg::desc_t rd_desc
);
  import txtesc_pkg::*;

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign rd_desc = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/txtesc_back.sv -----
// ----------------------------------------------------------------------------
// txtesc_back
// Walks each queued run one byte a cycle, while the output is popped or empty, into a registered output stage.
// ----------------------------------------------------------------------------
module txtesc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  txtesc_pkg::desc_t q_desc,
  output logic              q_rd,
  output logic [7:0]        out_byte,
  output logic              last_of_run,
  output logic              empty,
  input  logic              pop
);
  import txtesc_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             out_valid;
  logic             load;
  logic             at_end;

  assign empty  = !out_valid;
  assign load   = q_valid && (!out_valid || pop);
  assign at_end = (idx == seq_len(q_desc) - 1'b1);
  assign q_rd   = load && at_end;

  // run position and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_end ? '0 : idx + 1'b1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= seq_char(q_desc, idx);
      last_of_run <= at_end;
    end
  end

endmodule

// ----- sv/text_escape_encoder.sv -----
// ----------------------------------------------------------------------------
// text_escape_encoder
// Escapes a byte stream as plain, JSON, URL percent or XML entity text.
// ----------------------------------------------------------------------------
// path: a transferred byte is written into the queue, and its first output
//   byte is registered in the output stage when that stage is free or popped
// throughput: one output byte per cycle while the output is popped or empty,
//   set by the back end's run walker; a run is 1 to 6 bytes long
// reset: synchronous; escape_mode returns to plain, queue and output empty
module text_escape_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [txtesc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic [7:0]                    in_byte,
  input  logic                          push,
  output logic                          full,
  output logic [7:0]                    out_byte,
  output logic                          last_of_run,
  output logic                          empty,
  input  logic                          pop
);
  import txtesc_pkg::*;

  mode_t escape_mode;
  logic  q_wr;
  logic  q_rd;
  logic  q_full;
  logic  q_valid;
  desc_t q_wr_desc;
  desc_t q_rd_desc;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= MODE_PLAIN;
    end else if (psel && penable && pwrite && paddr == ADDR_ESCAPE_MODE) begin
      escape_mode <= mode_t'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ESCAPE_MODE) prdata = {30'd0, escape_mode};
  end

  assign full = q_full;

  // front: accept and classify
  txtesc_front u_front (
    .mode      (escape_mode),
    .in_byte   (in_byte),
    .push      (push),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_desc (q_wr_desc)
  );

  // queue between the two halves
  txtesc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_desc (q_wr_desc),
    .full    (q_full),
    .rd      (q_rd),
    .valid   (q_valid),
    .rd_desc (q_rd_desc)
  );

  // back: expand runs onto the output
  txtesc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_desc      (q_rd_desc),
    .q_rd        (q_rd),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
